// ----- rtl/core/gydr_pkg.sv -----
// Shared types and constants of the yaw gyro delta reporter.
// Holds the sequencer state codes, control/status structs and fixed-point constants.
// No dependencies.
package gydr_pkg;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BIAS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SIGN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEADBAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SILENCE_US = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP_US     = 3'd6;

  // Register reset values
  localparam logic [16:0] ALPHA_RST     = 17'd16384;
  localparam logic [23:0] DEADBAND_RST  = 24'd22938;
  localparam logic [26:0] THRESHOLD_RST = 27'd209715;
  localparam logic [23:0] SILENCE_RST   = 24'd200000;
  localparam logic [23:0] MAX_GAP_RST   = 24'd100000;

  // Arithmetic constants
  localparam logic [16:0] ALPHA_ONE     = 17'h10000;
  localparam logic [23:0] TIMER_MAX     = 24'hFFFFFF;
  localparam logic [15:0] RATE_HALF     = 16'd65;         // half of 131
  localparam logic [49:0] DIST_HALF     = 50'd31250;      // half of 62500
  localparam logic [28:0] SILENCE_FLOOR = 29'd1048;       // 0.001 degree, Q8.20

  // Constant divisors and their reciprocals, 2^39/131 and 2^47/62500 rounded down
  localparam logic [31:0] DIV_RATE = 32'd131;
  localparam logic [31:0] DIV_DIST = 32'd62500;
  localparam logic [31:0] RCP_RATE = 32'd4196609266;
  localparam logic [31:0] RCP_DIST = 32'd2251799813;

  // Sequencer states, one-hot
  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_DA   = 16'h0002,   // multiply by reciprocal
    S_DB   = 16'h0004,   // multiply quotient estimate back by divisor
    S_DC   = 16'h0008,   // correct quotient digit
    S_RATE = 16'h0010,
    S_BIAS = 16'h0020,
    S_DIFF = 16'h0040,
    S_FMUL = 16'h0080,
    S_FSUM = 16'h0100,
    S_FRND = 16'h0200,
    S_DBND = 16'h0400,
    S_DMUL = 16'h0800,
    S_DNUM = 16'h1000,
    S_ACC  = 16'h2000,
    S_DEC  = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic start;      // accepted item is a usable sample
    logic last;       // current quotient digit is the last one
    logic sel_dist;   // divider works on the distance term
    logic report;     // pending delta must be sent
    logic out_free;   // output register can take a result
  } stat_t;

  // Control from the sequencer to the datapath
  typedef struct packed {
    state_t st;
    logic   mul_go;
  } ctrl_t;

endpackage

// ----- rtl/core/gydr_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing; operands are selected by the datapath.
module gydr_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  logic [63:0] p_nxt;

  // Form the product
  assign p_nxt = 64'(a) * 64'(b);

  // Hold the product until the next multiply step
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

endmodule

// ----- rtl/core/gydr_seq.sv -----
// Step sequencer of the yaw gyro delta reporter.
// Depends on gydr_pkg for the state codes and the control/status structs.
module gydr_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  gydr_pkg::stat_t stat,
  output gydr_pkg::ctrl_t ctl
);
  import gydr_pkg::*;

  state_t st_r;
  state_t st_nxt;

  // Advance through the per-sample steps
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (stat.start) st_nxt = S_DA;
      S_DA:   st_nxt = S_DB;
      S_DB:   st_nxt = S_DC;
      S_DC: begin
        if (!stat.last) begin
          st_nxt = S_DA;
        end else if (stat.sel_dist) begin
          st_nxt = S_ACC;
        end else begin
          st_nxt = S_RATE;
        end
      end
      S_RATE: st_nxt = S_BIAS;
      S_BIAS: st_nxt = S_DIFF;
      S_DIFF: st_nxt = S_FMUL;
      S_FMUL: st_nxt = S_FSUM;
      S_FSUM: st_nxt = S_FRND;
      S_FRND: st_nxt = S_DBND;
      S_DBND: st_nxt = S_DMUL;
      S_DMUL: st_nxt = S_DNUM;
      S_DNUM: st_nxt = S_DA;
      S_ACC:  st_nxt = S_DEC;
      S_DEC:  st_nxt = stat.report ? S_OUT : S_IDLE;
      S_OUT:  if (stat.out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Drive the datapath
  assign ctl.st     = st_r;
  assign ctl.mul_go = (st_r == S_DA) || (st_r == S_DB) || (st_r == S_FMUL) || (st_r == S_DMUL);

endmodule

// ----- rtl/core/gyro_yaw_delta_reporter_core.sv -----
// Top level of the yaw gyro delta reporter: registers, datapath and handshakes.
// Depends on gydr_pkg, gydr_seq and gydr_mul.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item per gyro read: a raw yaw
//   sample, a read-ok flag and the microseconds since the previous item. The
//   first item after reset only primes the timers. Failed reads and samples
//   whose gap is zero or above max_gap_us are accepted and give no result.
//   A usable sample runs through one shared 32x32 multiplier under a step
//   sequencer: the division by 131 is one reciprocal step and the division by
//   62500 takes three, each step a reciprocal multiply, a back multiply and a
//   correction; in_ready is low while the item occupies the block.
//   A result (out_valid/out_ready) is loaded in the report step and waits
//   in the output register until taken; the next item is accepted
//   while it waits. If a new report is due while the old one is still not
//   taken, the block holds in its report step.
//   Configuration writes (cfg_valid/cfg_ready) are always taken and belong in
//   idle time. Reset (rst_n low, synchronous) clears state and timers, restores
//   the register defaults and empties the output register.
module gyro_yaw_delta_reporter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 in_rate_raw,
  input  logic                               in_sample_ok,
  input  logic [19:0]                        in_elapsed_us,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [28:0]                 out_yaw_delta,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gydr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gydr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gydr_pkg::*;

  // Saturating timer add
  function automatic logic [23:0] tmr_add(input logic [23:0] t, input logic [19:0] e);
    logic [24:0] s;
    s = {1'b0, t} + {5'd0, e};
    return s[24] ? TIMER_MAX : s[23:0];
  endfunction

  // Saturate to the 26-bit rate range
  function automatic logic signed [25:0] sat26(input logic signed [28:0] v);
    if (v > 29'sd33554431) begin
      return 26'sh1FFFFFF;
    end else if (v < -29'sd33554432) begin
      return 26'sh2000000;
    end
    return v[25:0];
  endfunction

  // Saturate to the 29-bit angle range
  function automatic logic signed [28:0] sat29(input logic signed [35:0] v);
    if (v > 36'sd268435455) begin
      return 29'sh0FFFFFFF;
    end else if (v < -36'sd268435456) begin
      return 29'sh10000000;
    end
    return v[28:0];
  endfunction

  // Configuration registers
  logic signed [24:0] bias_r;
  logic               invert_r;
  logic [16:0]        alpha_r;
  logic [23:0]        deadband_r;
  logic [26:0]        thresh_r;
  logic [23:0]        max_sil_r;
  logic [23:0]        max_gap_r;

  // Persistent state
  logic               primed_r;
  logic signed [25:0] f_r;
  logic signed [28:0] pending_r;
  logic [23:0]        gap_r;
  logic [23:0]        tsr_r;
  logic               out_valid_r;
  logic signed [28:0] out_data_r;

  // Working registers
  logic [31:0]        v_r;
  logic [24:0]        q0_r;
  logic [34:0]        quo_r;
  logic [31:0]        num_r;
  logic [1:0]         cnt_r;
  logic               sel_r;
  logic               neg_r;
  logic               sgn_r;
  logic [26:0]        mag_r;
  logic signed [26:0] y_r;
  logic signed [44:0] n_r;
  logic [23:0]        dt_r;

  ctrl_t       ctl;
  stat_t       stat;
  logic [63:0] p_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  logic               in_fire;
  logic               out_free;
  logic [23:0]        gap_sum;
  logic [15:0]        raw_mag;
  logic [16:0]        alpha_eff;
  logic [31:0]        d_const;
  logic [31:0]        rcp_const;
  logic [24:0]        q0_w;
  logic [31:0]        rem;
  logic               corr;
  logic [24:0]        qd;
  logic [31:0]        rf;
  logic signed [26:0] qs;
  logic signed [26:0] be;
  logic signed [26:0] ydiff;
  logic signed [26:0] fe;
  logic signed [26:0] dpos;
  logic signed [26:0] dneg;
  logic signed [44:0] fsh;
  logic signed [44:0] p45;
  logic signed [44:0] rs;
  logic [25:0]        fm;
  logic [49:0]        s50;
  logic signed [35:0] pe;
  logic signed [35:0] qe;
  logic signed [35:0] acc_sum;
  logic [28:0]        pm;

  gydr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  gydr_mul u_mul (
    .clk (clk),
    .en  (ctl.mul_go),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  // Handshakes
  assign in_ready  = (ctl.st == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_yaw_delta = out_data_r;

  // Input item decode
  assign gap_sum   = tmr_add(gap_r, in_elapsed_us);
  assign raw_mag   = in_rate_raw[15] ? 16'(-in_rate_raw) : 16'(in_rate_raw);
  assign alpha_eff = (alpha_r[16] && (alpha_r[15:0] != 16'd0)) ? ALPHA_ONE : alpha_r;

  // Divider by constant: reciprocal estimate, back multiply, one-step correction
  assign d_const   = sel_r ? DIV_DIST : DIV_RATE;
  assign rcp_const = sel_r ? RCP_DIST : RCP_RATE;
  assign q0_w      = sel_r ? 25'(p_r[63:47]) : p_r[63:39];
  assign rem       = v_r - p_r[31:0];
  assign corr      = (rem >= d_const);
  assign qd        = q0_r + 25'(corr);
  assign rf        = corr ? (rem - d_const) : rem;

  // Rate, bias and filter difference
  assign qs    = {2'b00, quo_r[24:0]};
  assign be    = {{2{bias_r[24]}}, bias_r};
  assign ydiff = invert_r ? (be - y_r) : (y_r - be);
  assign fe    = {f_r[25], f_r};
  assign dpos  = y_r - fe;
  assign dneg  = fe - y_r;

  // Filter update and rounding, ties away from zero
  assign fsh = {{3{f_r[25]}}, f_r, 16'd0};
  assign p45 = {3'd0, p_r[41:0]};
  assign rs  = n_r + (n_r[44] ? 45'sd32767 : 45'sd32768);
  assign fm  = f_r[25] ? 26'(-f_r) : 26'(f_r);

  // Distance numerator, accumulation and report test
  assign s50     = p_r[49:0] + DIST_HALF;
  assign pe      = {{7{pending_r[28]}}, pending_r};
  assign qe      = {1'b0, quo_r};
  assign acc_sum = sgn_r ? (pe - qe) : (pe + qe);
  assign pm      = pending_r[28] ? 29'(-pending_r) : 29'(pending_r);

  // Status to the sequencer
  assign stat.start    = in_fire && primed_r && in_sample_ok && (gap_sum != 24'd0) &&
                         (gap_sum <= max_gap_r);
  assign stat.last     = (cnt_r == 2'd0);
  assign stat.sel_dist = sel_r;
  assign stat.report   = (pm >= {2'b00, thresh_r}) ||
                         ((tsr_r >= max_sil_r) && (pm > SILENCE_FLOOR));
  assign stat.out_free = out_free;

  // Select multiplier operands per step
  always_comb begin
    case (ctl.st)
      S_DA: begin
        mul_a = v_r;
        mul_b = rcp_const;
      end
      S_DB: begin
        mul_a = 32'(q0_w);
        mul_b = d_const;
      end
      S_FMUL: begin
        mul_a = 32'(alpha_eff);
        mul_b = 32'(mag_r);
      end
      S_DMUL: begin
        mul_a = 32'(mag_r);
        mul_b = 32'(dt_r);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r     <= 25'sd0;
      invert_r   <= 1'b0;
      alpha_r    <= ALPHA_RST;
      deadband_r <= DEADBAND_RST;
      thresh_r   <= THRESHOLD_RST;
      max_sil_r  <= SILENCE_RST;
      max_gap_r  <= MAX_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RATE_BIAS:      bias_r     <= cfg_data[24:0];
        CFG_INVERT_SIGN:    invert_r   <= cfg_data[0];
        CFG_FILTER_ALPHA:   alpha_r    <= cfg_data[16:0];
        CFG_RATE_DEADBAND:  deadband_r <= cfg_data[23:0];
        CFG_SEND_THRESHOLD: thresh_r   <= cfg_data[26:0];
        CFG_MAX_SILENCE_US: max_sil_r  <= cfg_data[23:0];
        CFG_MAX_GAP_US:     max_gap_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Timers, filter state, pending delta and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r    <= 1'b0;
      f_r         <= 26'sd0;
      pending_r   <= 29'sd0;
      gap_r       <= 24'd0;
      tsr_r       <= 24'd0;
      out_valid_r <= 1'b0;
    end else begin
      // Prime on the first item, then advance the report timer and advance the gap timer or clear it on a good read
      if (in_fire) begin
        if (!primed_r) begin
          primed_r <= 1'b1;
          gap_r    <= 24'd0;
          tsr_r    <= 24'd0;
        end else begin
          gap_r <= in_sample_ok ? 24'd0 : gap_sum;
          tsr_r <= tmr_add(tsr_r, in_elapsed_us);
        end
      end
      if (ctl.st == S_FRND) begin
        f_r <= sat26(rs[44:16]);
      end
      // Drop filtered rates inside the deadband
      if ((ctl.st == S_DBND) && ({2'b00, fm} < {4'd0, deadband_r})) begin
        f_r <= 26'sd0;
      end
      if (ctl.st == S_ACC) begin
        pending_r <= sat29(acc_sum);
      end
      // Load a report, or let the receiver drain the output register
      if ((ctl.st == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
        pending_r   <= 29'sd0;
        tsr_r       <= 24'd0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the arithmetic steps
  always_ff @(posedge clk) begin
    if ((ctl.st == S_OUT) && out_free) begin
      out_data_r <= pending_r;
    end
    case (ctl.st)
      S_IDLE: begin
        if (stat.start) begin
          v_r   <= {raw_mag, RATE_HALF};
          neg_r <= in_rate_raw[15];
          dt_r  <= gap_sum;
          sel_r <= 1'b0;
          cnt_r <= 2'd0;
          quo_r <= 35'd0;
        end
      end
      S_DB: q0_r <= q0_w;
      S_DC: begin
        quo_r <= {quo_r[18:0], 16'd0} + 35'(qd);
        if (cnt_r != 2'd0) begin
          v_r   <= {rf[15:0], num_r[31:16]};
          num_r <= {num_r[15:0], 16'd0};
          cnt_r <= cnt_r - 2'd1;
        end
      end
      S_RATE: y_r <= neg_r ? -qs : qs;
      S_BIAS: y_r <= 27'(sat26({{2{ydiff[26]}}, ydiff}));
      S_DIFF: begin
        sgn_r <= dpos[26];
        mag_r <= dpos[26] ? 27'(dneg) : 27'(dpos);
      end
      S_FSUM: n_r <= sgn_r ? (fsh - p45) : (fsh + p45);
      S_DBND: begin
        sgn_r <= f_r[25];
        mag_r <= ({2'b00, fm} < {4'd0, deadband_r}) ? 27'd0 : 27'(fm);
      end
      S_DNUM: begin
        v_r   <= {14'd0, s50[49:32]};
        num_r <= s50[31:0];
        cnt_r <= 2'd2;
        sel_r <= 1'b1;
        quo_r <= 35'd0;
      end
      default: ;
    endcase
  end

  // Corrected remainder always lies below the divisor
  a_dc_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.st == S_DC) |-> (rf < d_const))
    else $error("divider remainder not below divisor");

  // A loaded report clears the pending delta and the report timer
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    ((ctl.st == S_OUT) && out_free) |=> (out_valid_r && (pending_r == 29'sd0) &&
                                         (tsr_r == 24'd0)))
    else $error("report did not load output or clear state");

  // After the deadband step the rate magnitude is zero or at least the deadband
  a_dband: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.st == S_DBND) |=> ((mag_r == 27'd0) || (mag_r >= {3'd0, $past(deadband_r)})))
    else $error("rate inside deadband passed on");

  // A good read on a primed block always consumes the gap
  a_gap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && primed_r && in_sample_ok) |=> (gap_r == 24'd0))
    else $error("gap not cleared by good sample");

endmodule
